// ===== rtl/timed_event_queue_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the timed event queue RTL
// ---------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/teq_pkg.sv =====
// ---------------------------------------------------------------------------
// teq_pkg
// Operation codes and word-field helpers for the timed event queue.
// ---------------------------------------------------------------------------
package teq_pkg;

    typedef enum logic [3:0] {
        OP_TICK         = 4'd0,
        OP_SET_PHASE    = 4'd1,
        OP_SCHEDULE     = 4'd2,
        OP_RESCHEDULE   = 4'd3,
        OP_REPEAT       = 4'd4,
        OP_EXECUTE      = 4'd5,
        OP_PEEK         = 4'd6,
        OP_DELAY_ALL    = 4'd7,
        OP_DELAY_GROUP  = 4'd8,
        OP_CANCEL_ID    = 4'd9,
        OP_CANCEL_GROUP = 4'd10,
        OP_NEXT_TIME    = 4'd11
    } t_op;

    localparam int GROUP_LSB = 17;
    localparam int PHASE_LSB = 25;

    // Group 1-8 maps to one bit of word[24:17]; anything else to none
    function automatic logic [7:0] group_mask(input logic [3:0] g);
        logic [7:0] m;
        m = '0;
        if (g >= 4'd1 && g <= 4'd8) begin
            m[3'(g - 4'd1)] = 1'b1;
        end
        return m;
    endfunction

    // Phase 1-7 maps to one bit of word[31:25]; anything else to none
    function automatic logic [6:0] phase_mask(input logic [3:0] p);
        logic [6:0] m;
        m = '0;
        if (p >= 4'd1 && p <= 4'd7) begin
            m[p[2:0] - 3'd1] = 1'b1;
        end
        return m;
    endfunction

endpackage

// ===== rtl/teq_ram.sv =====
// ---------------------------------------------------------------------------
// teq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module teq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/timed_event_queue.sv =====
// ---------------------------------------------------------------------------
// timed_event_queue
// Table of timed events with a clock, scanned through two entry memories.
// ---------------------------------------------------------------------------
// One command beat enters on the s_ channel (tuser = operation, tdata =
// id, amount, group, phase) and exactly one result beat leaves on the m_
// channel (tdata = id and time, tuser = table full flag).
// Due times and event words live in two RAMs of CAPACITY entries with a
// registered read; valid bits are flip-flops. Most table operations are
// built from sweeps over all entries, each with its closing step:
//   tick, set_phase, delay_all, unknown codes: no sweep.
//   cancel_id, cancel_group, next_time: one sweep.
//   schedule: a free-entry sweep, then (bumps+1) time-taken sweeps.
//   reschedule: a cancel sweep ahead of schedule.
//   repeat: a minimum sweep, then (bumps+1) time-taken sweeps.
//   execute, peek: one minimum sweep per discarded entry plus one.
//   delay_group: a marking sweep, then per moved member a minimum sweep and
//   its time-taken sweeps.
// One command is in work at a time; the next command is taken once the
// result sits in the output register, which holds while the receiver
// stalls. Reset empties the table, zeroes the clock and the phase.
// ---------------------------------------------------------------------------
`include "timed_event_queue_macros.svh"

module timed_event_queue #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [15:0] event_id, [47:16] time_amount, [51:48] group_number,
    // [55:52] phase_number
    input  logic [55:0] i_s_tdata,
    // [3:0] operation
    input  logic [3:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] result_id, [47:16] result_time
    output logic [47:0] o_m_tdata,
    // [0] table_full
    output logic [0:0]  o_m_tuser
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = IW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_POST, S_WRITE, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        K_MIN, K_TAKEN, K_CANCEL, K_FREE, K_MARK
    } t_kind;

    t_state          r_state;
    t_kind           r_kind;
    teq_pkg::t_op    r_op;
    logic [15:0]     r_id;
    logic [31:0]     r_amt;
    logic [3:0]      r_grp;
    logic [3:0]      r_ph;
    logic [31:0]     r_clock;
    logic [2:0]      r_phase;
    logic [CAPACITY-1:0] r_valid;
    logic [CAPACITY-1:0] r_move;
    logic [CW-1:0]   r_cnt;
    logic            r_pv;
    logic [IW-1:0]   r_pidx;
    logic            r_found;
    logic            r_hit;
    logic [31:0]     r_btime;
    logic [31:0]     r_bword;
    logic [IW-1:0]   r_bidx;
    logic [31:0]     r_t;
    logic [31:0]     r_lim;
    logic [IW-1:0]   r_widx;
    logic [15:0]     r_res_id;
    logic [31:0]     r_res_time;
    logic            r_res_full;
    logic            r_ovalid;
    logic [47:0]     r_odata;
    logic            r_ofull;

    logic [31:0]     d_time;
    logic [31:0]     d_word;
    logic            d_v;
    logic [7:0]      gmask;
    logic [6:0]      cur_ph;
    logic            cand;
    logic            cancel_hit;
    logic            discard;
    logic            time_we;
    logic            word_we;
    logic [31:0]     new_word;
    logic [IW-1:0]   raddr;
    teq_pkg::t_op    in_op;

    assign in_op    = teq_pkg::t_op'(i_s_tuser);
    assign raddr    = r_cnt[IW-1:0];
    assign gmask    = teq_pkg::group_mask(r_grp);
    assign cur_ph   = teq_pkg::phase_mask({1'b0, r_phase});
    assign new_word = {teq_pkg::phase_mask(r_ph), gmask, 1'b0, r_id};
    assign d_v      = r_valid[r_pidx];
    assign time_we  = (r_state == S_WRITE);
    assign word_we  = (r_state == S_WRITE) &&
                      (r_op == teq_pkg::OP_SCHEDULE || r_op == teq_pkg::OP_RESCHEDULE);

    teq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (r_widx),
        .i_wdata (r_t),
        .i_raddr (raddr),
        .o_rdata (d_time)
    );

    teq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (word_we),
        .i_waddr (r_widx),
        .i_wdata (new_word),
        .i_raddr (raddr),
        .o_rdata (d_word)
    );

    // Candidate and match terms for the entry coming out of the RAMs
    always_comb begin
        case (r_op)
            teq_pkg::OP_NEXT_TIME:   cand = d_v && (d_word[15:0] == r_id);
            teq_pkg::OP_DELAY_GROUP: cand = r_move[r_pidx];
            default:                 cand = d_v;
        endcase
        if (r_op == teq_pkg::OP_CANCEL_GROUP) begin
            cancel_hit = d_v && ((d_word[24:17] & gmask) != 8'd0);
        end else begin
            cancel_hit = d_v && (d_word[15:0] == r_id);
        end
        discard = (cur_ph != 7'd0) && (r_bword[31:25] != 7'd0) &&
                  ((r_bword[31:25] & cur_ph) == 7'd0);
    end

    // Sequencer: command capture, sweeps, write-back and result hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_MIN;
            r_clock  <= '0;
            r_phase  <= '0;
            r_valid  <= '0;
            r_move   <= '0;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_found  <= 1'b0;
            r_hit    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_m_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt   <= '0;
                    r_pv    <= 1'b0;
                    r_found <= 1'b0;
                    r_hit   <= 1'b0;
                    if (i_s_tvalid) begin
                        r_op       <= in_op;
                        r_id       <= i_s_tdata[15:0];
                        r_amt      <= i_s_tdata[47:16];
                        r_grp      <= i_s_tdata[51:48];
                        r_ph       <= i_s_tdata[55:52];
                        r_res_id   <= '0;
                        r_res_time <= '0;
                        r_res_full <= 1'b0;
                        case (in_op)
                            teq_pkg::OP_TICK: begin
                                r_clock <= r_clock + i_s_tdata[47:16];
                                r_state <= S_DONE;
                            end
                            teq_pkg::OP_SET_PHASE: begin
                                if (i_s_tdata[55:52] >= 4'd1 && i_s_tdata[55:52] <= 4'd7) begin
                                    r_phase <= i_s_tdata[54:52];
                                end
                                r_state <= S_DONE;
                            end
                            teq_pkg::OP_SCHEDULE: begin
                                r_kind  <= K_FREE;
                                r_state <= S_SCAN;
                            end
                            teq_pkg::OP_RESCHEDULE, teq_pkg::OP_CANCEL_ID,
                            teq_pkg::OP_CANCEL_GROUP: begin
                                r_kind  <= K_CANCEL;
                                r_state <= S_SCAN;
                            end
                            teq_pkg::OP_REPEAT, teq_pkg::OP_EXECUTE,
                            teq_pkg::OP_PEEK, teq_pkg::OP_NEXT_TIME: begin
                                r_kind  <= K_MIN;
                                r_state <= S_SCAN;
                            end
                            teq_pkg::OP_DELAY_ALL: begin
                                r_clock <= (i_s_tdata[47:16] < r_clock) ?
                                           r_clock - i_s_tdata[47:16] : 32'd0;
                                r_state <= S_DONE;
                            end
                            teq_pkg::OP_DELAY_GROUP: begin
                                r_lim   <= r_clock + i_s_tdata[47:16];
                                r_kind  <= K_MARK;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Issue the next read, one entry per cycle
                    if (r_cnt < CW'(CAPACITY)) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_pv   <= 1'b1;
                        r_pidx <= raddr;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_state <= S_POST;
                        end
                    end
                    // Fold in the entry whose data just arrived
                    if (r_pv) begin
                        case (r_kind)
                            K_MIN: begin
                                if (cand && (!r_found || d_time < r_btime)) begin
                                    r_found <= 1'b1;
                                    r_btime <= d_time;
                                    r_bword <= d_word;
                                    r_bidx  <= r_pidx;
                                end
                            end
                            K_TAKEN: begin
                                if (d_v && d_time == r_t) begin
                                    r_hit <= 1'b1;
                                end
                            end
                            K_CANCEL: begin
                                if (cancel_hit) begin
                                    r_valid[r_pidx] <= 1'b0;
                                end
                            end
                            K_FREE: begin
                                if (!d_v && !r_found) begin
                                    r_found <= 1'b1;
                                    r_bidx  <= r_pidx;
                                end
                            end
                            default: begin
                                r_move[r_pidx] <= d_v && ((d_word[24:17] & gmask) != 8'd0)
                                                  && (d_time < r_lim);
                            end
                        endcase
                    end
                end
                S_POST: begin
                    r_cnt   <= '0;
                    r_pv    <= 1'b0;
                    r_found <= 1'b0;
                    r_hit   <= 1'b0;
                    case (r_kind)
                        K_CANCEL: begin
                            if (r_op == teq_pkg::OP_RESCHEDULE) begin
                                r_kind  <= K_FREE;
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        K_FREE: begin
                            if (r_found) begin
                                r_widx  <= r_bidx;
                                r_t     <= r_clock + r_amt;
                                r_kind  <= K_TAKEN;
                                r_state <= S_SCAN;
                            end else begin
                                r_res_full <= 1'b1;
                                r_state    <= S_DONE;
                            end
                        end
                        K_TAKEN: begin
                            // Bump past an occupied time and look again
                            if (r_hit) begin
                                r_t     <= r_t + 32'd1;
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_WRITE;
                            end
                        end
                        K_MARK: begin
                            r_kind  <= K_MIN;
                            r_state <= S_SCAN;
                        end
                        default: begin
                            case (r_op)
                                teq_pkg::OP_REPEAT: begin
                                    if (r_found) begin
                                        r_valid[r_bidx] <= 1'b0;
                                        r_widx  <= r_bidx;
                                        r_t     <= r_clock + r_amt;
                                        r_kind  <= K_TAKEN;
                                        r_state <= S_SCAN;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end
                                teq_pkg::OP_EXECUTE, teq_pkg::OP_PEEK: begin
                                    if (r_found && r_btime <= r_clock && discard) begin
                                        r_valid[r_bidx] <= 1'b0;
                                        r_state <= S_SCAN;
                                    end else begin
                                        r_state <= S_DONE;
                                        if (r_found && r_btime <= r_clock) begin
                                            r_res_id <= r_bword[15:0];
                                            if (r_op == teq_pkg::OP_EXECUTE) begin
                                                r_valid[r_bidx] <= 1'b0;
                                            end
                                        end
                                    end
                                end
                                teq_pkg::OP_NEXT_TIME: begin
                                    r_res_time <= r_found ? r_btime : 32'd0;
                                    r_state    <= S_DONE;
                                end
                                teq_pkg::OP_DELAY_GROUP: begin
                                    if (r_found) begin
                                        r_move[r_bidx] <= 1'b0;
                                        r_widx  <= r_bidx;
                                        r_t     <= r_btime + r_amt;
                                        r_kind  <= K_TAKEN;
                                        r_state <= S_SCAN;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end
                                default: begin
                                    r_state <= S_DONE;
                                end
                            endcase
                        end
                    endcase
                end
                S_WRITE: begin
                    // Time (and word) land in the RAMs this cycle
                    r_valid[r_widx] <= 1'b1;
                    if (r_op == teq_pkg::OP_DELAY_GROUP) begin
                        r_kind  <= K_MIN;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hand the result to the output register once it is free
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {r_res_time, r_res_id};
                        r_ofull  <= r_res_full;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ofull;

    `TEQ_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state != S_IDLE, "accepted beat did not start work")
    `TEQ_ASSERT_NOW(a_pipe_in_scan, i_clk, i_rst_n, r_pv, r_state == S_SCAN, "read data pending outside a sweep")
    `TEQ_ASSERT_NOW(a_pipe_index, i_clk, i_rst_n, r_pv, r_pidx == IW'(r_cnt - 1'b1), "sweep index out of step")
    `TEQ_ASSERT_NOW(a_insert_free, i_clk, i_rst_n, word_we, !r_valid[r_widx], "insert into an occupied entry")

endmodule
